// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the heap sort engine.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, suspended while reset is high.
`define HSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heap sort engine check failed");

// Next-cycle implication, suspended while reset is high.
`define HSE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap sort engine check failed");

`endif

// File: rtl/hse_pkg.sv
// Package of the heap sort engine: sequencer states and the output control word.
// Depends on nothing.
package hse_pkg;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SIFT_A,
    S_SIFT_H,
    S_SIFT_L,
    S_SIFT_R,
    S_SIFT_C,
    S_SIFT_D,
    S_SW0,
    S_SW1,
    S_SW2,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  typedef struct packed {
    logic load;
    logic last;
    logic ovf;
  } out_ctl_t;

endpackage

// File: rtl/hse_if.sv
// Valid/ready channel interfaces of the heap sort engine: input words and sorted words.
// Depends on nothing.
interface hse_in_if #(parameter int VALUE_WIDTH = 32);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic                   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface hse_out_if #(parameter int VALUE_WIDTH = 32);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] sorted_value;
  logic                   last_out;
  logic                   overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

// File: rtl/hse_cmp.sv
// Shared signed (two's complement) greater-than comparator of the heap sort engine.
// Depends on nothing.
module hse_cmp #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         gt
);

  assign gt = $signed(a) > $signed(b);

endmodule

// File: rtl/hse_mem.sv
// Element store of the heap sort engine: one write port, one read port, registered read.
// Depends on nothing.
module hse_mem #(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/hse_seq.sv
// Sequencer of the heap sort engine: load, heap build, sort-down and emit over one store.
// Depends on hse_pkg and hse_cmp.
module hse_seq
  import hse_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_ITEMS   = 64,
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_last,
  input  logic                   out_free,
  output out_ctl_t               out_ctl,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [VALUE_WIDTH-1:0] mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  input  logic [VALUE_WIDTH-1:0] mem_rdata
);

  localparam int EW = AW + 2;

  state_t                 state, state_next;
  logic [CW-1:0]          fill, fill_next;
  logic                   dropped, dropped_next;
  logic [AW-1:0]          idx, idx_next;
  logic [AW-1:0]          bnode, bnode_next;
  logic [CW-1:0]          hn, hn_next;
  logic [AW-1:0]          endp, endp_next;
  logic [VALUE_WIDTH-1:0] hold, hold_next;
  logic [VALUE_WIDTH-1:0] best, best_next;
  logic [AW-1:0]          bidx, bidx_next;
  logic [VALUE_WIDTH-1:0] tmp, tmp_next;
  logic [AW-1:0]          k, k_next;
  logic                   build, build_next;

  logic [EW-1:0]          l_e, r_e, hn_e;
  logic [VALUE_WIDTH-1:0] cmp_a, cmp_b;
  logic                   gt;
  logic                   store;
  logic [CW-1:0]          n_in;

  assign l_e  = EW'({idx, 1'b1});
  assign r_e  = l_e + EW'(1);
  assign hn_e = EW'(hn);

  // one comparator serves both the child pick and the sift decision
  assign cmp_a = (state == S_SIFT_C) ? mem_rdata : best;
  assign cmp_b = (state == S_SIFT_C) ? best : hold;

  hse_cmp #(.W(VALUE_WIDTH)) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .gt (gt)
  );

  assign store = fill < CW'(MAX_ITEMS);
  assign n_in  = store ? fill + CW'(1) : fill;
  assign in_ready = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      fill    <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      dropped <= dropped_next;
    end
    idx   <= idx_next;
    bnode <= bnode_next;
    hn    <= hn_next;
    endp  <= endp_next;
    hold  <= hold_next;
    best  <= best_next;
    bidx  <= bidx_next;
    tmp   <= tmp_next;
    k     <= k_next;
    build <= build_next;
  end

  always_comb begin
    logic sift_done;
    state_next   = state;
    fill_next    = fill;
    dropped_next = dropped;
    idx_next     = idx;
    bnode_next   = bnode;
    hn_next      = hn;
    endp_next    = endp;
    hold_next    = hold;
    best_next    = best;
    bidx_next    = bidx;
    tmp_next     = tmp;
    k_next       = k;
    build_next   = build;
    mem_we       = 1'b0;
    mem_waddr    = idx;
    mem_wdata    = hold;
    mem_raddr    = '0;
    out_ctl      = '0;
    out_value    = mem_rdata;
    sift_done    = 1'b0;

    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          mem_we       = store;
          mem_waddr    = fill[AW-1:0];
          mem_wdata    = in_value;
          fill_next    = n_in;
          dropped_next = dropped | ~store;
          if (in_last) begin
            k_next = '0;
            if (n_in < CW'(2)) begin
              state_next = S_EMIT_RD;
            end else begin
              build_next = 1'b1;
              hn_next    = n_in;
              bnode_next = AW'((n_in >> 1) - CW'(1));
              idx_next   = AW'((n_in >> 1) - CW'(1));
              state_next = S_SIFT_A;
            end
          end
        end
      end
      S_SIFT_A: begin
        mem_raddr  = idx;
        state_next = S_SIFT_H;
      end
      S_SIFT_H: begin
        hold_next  = mem_rdata;
        state_next = S_SIFT_L;
      end
      S_SIFT_L: begin
        if (l_e < hn_e) begin
          mem_raddr  = l_e[AW-1:0];
          state_next = S_SIFT_R;
        end else begin
          mem_we    = 1'b1;
          sift_done = 1'b1;
        end
      end
      S_SIFT_R: begin
        best_next = mem_rdata;
        bidx_next = l_e[AW-1:0];
        if (r_e < hn_e) begin
          mem_raddr  = r_e[AW-1:0];
          state_next = S_SIFT_C;
        end else begin
          state_next = S_SIFT_D;
        end
      end
      S_SIFT_C: begin
        if (gt) begin
          best_next = mem_rdata;
          bidx_next = r_e[AW-1:0];
        end
        state_next = S_SIFT_D;
      end
      S_SIFT_D: begin
        mem_we = 1'b1;
        if (gt) begin
          mem_wdata  = best;
          idx_next   = bidx;
          state_next = S_SIFT_L;
        end else begin
          sift_done = 1'b1;
        end
      end
      S_SW0: begin
        mem_raddr  = '0;
        state_next = S_SW1;
      end
      S_SW1: begin
        tmp_next   = mem_rdata;
        mem_raddr  = endp;
        state_next = S_SW2;
      end
      S_SW2: begin
        mem_we     = 1'b1;
        mem_waddr  = endp;
        mem_wdata  = tmp;
        hold_next  = mem_rdata;
        idx_next   = '0;
        hn_next    = CW'(endp);
        state_next = S_SIFT_L;
      end
      S_EMIT_RD: begin
        mem_raddr = k;
        if (out_free) begin
          state_next = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        out_ctl.load = 1'b1;
        out_ctl.ovf  = dropped;
        out_ctl.last = (EW'(k) + EW'(1)) == EW'(fill);
        if (out_ctl.last) begin
          fill_next    = '0;
          dropped_next = 1'b0;
          state_next   = S_LOAD;
        end else begin
          k_next     = k + AW'(1);
          state_next = S_EMIT_RD;
        end
      end
      default: state_next = S_LOAD;
    endcase

    if (sift_done) begin
      if (build) begin
        if (bnode == '0) begin
          build_next = 1'b0;
          endp_next  = AW'(fill - CW'(1));
          state_next = S_SW0;
        end else begin
          bnode_next = bnode - AW'(1);
          idx_next   = bnode - AW'(1);
          state_next = S_SIFT_A;
        end
      end else if (endp == AW'(1)) begin
        state_next = S_EMIT_RD;
      end else begin
        endp_next  = endp - AW'(1);
        state_next = S_SW0;
      end
    end
  end

endmodule

// File: rtl/heap_sort_engine.sv
// Words load one per cycle; after the word marked last the heap is built and sorted in place
// through the store's single read port and the one shared comparator, and each sorted word
// is read from the store and then loaded into the output register once it is free.
// Sets are handled one at a time.
// Reset (rst, synchronous, active high) empties the set, clears the overflow mark and the
// output valid flag; the store itself is not cleared and is only read where written.
module heap_sort_engine
  import hse_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_ITEMS   = 64
) (
  input  logic      clk,
  input  logic      rst,
  hse_in_if.sink    items,
  hse_out_if.source results
);

  // store address and set-count widths follow the capacity
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  out_ctl_t               out_ctl;
  logic [VALUE_WIDTH-1:0] out_value;
  logic                   out_valid;
  logic                   out_free;

  // The output register parts the sequencer from the sink; it is free once its word
  // has gone or goes in this cycle.
  assign out_free = ~out_valid | results.ready;

  hse_mem #(
    .W     (VALUE_WIDTH),
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  hse_seq #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_ITEMS   (MAX_ITEMS),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_value  (items.value),
    .in_last   (items.last),
    .out_free  (out_free),
    .out_ctl   (out_ctl),
    .out_value (out_value),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Hold the sorted word until the sink takes it; a load only comes when the register
  // is free, so it takes priority over the drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ctl.load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (out_ctl.load) begin
      results.sorted_value <= out_value;
      results.last_out     <= out_ctl.last;
      results.overflow     <= out_ctl.ovf;
    end
  end

  assign results.valid = out_valid;

endmodule

// File: rtl/hse_chk.sv
// Port-level checker of the heap sort engine, bound to the top level below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hse_chk #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_last,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] sorted_value,
  input logic                   last_out,
  input logic                   overflow
);

  logic                   in_fire;
  logic                   out_fire;
  logic                   have_prev;
  logic [VALUE_WIDTH-1:0] prev_value;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  // remember the previous word of the current set
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_fire) begin
      have_prev <= ~last_out;
    end
    if (out_fire) begin
      prev_value <= sorted_value;
    end
  end

  `HSE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sorted_value) && $stable(last_out) && $stable(overflow))
  `HSE_ASSERT_NXT(a_busy_after_last, clk, rst, in_fire && in_last, !in_ready)
  `HSE_ASSERT_IMP(a_busy_mid_set, clk, rst, out_valid && !last_out, !in_ready)
  `HSE_ASSERT_IMP(a_ascending, clk, rst, out_fire && have_prev, $signed(sorted_value) >= $signed(prev_value))

endmodule

bind heap_sort_engine hse_chk #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_hse_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (items.valid),
  .in_ready     (items.ready),
  .in_last      (items.last),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .sorted_value (results.sorted_value),
  .last_out     (results.last_out),
  .overflow     (results.overflow)
);

// File: sim/tb.sv
// Self-checking bench for heap_sort_engine: random and directed sets of signed words in,
// ascending words out, compared against an in-bench heap sort held in a scoreboard class.
// Depends on rtl/hse_pkg.sv, rtl/hse_if.sv and rtl/heap_sort_engine.sv.
package sort_check_pkg;

  localparam int WORD_BITS = 32;
  localparam int CAPACITY  = 64;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic                 last;
    logic                 ovf;
  } sorted_word_t;

  class sort_scoreboard;
    logic [WORD_BITS-1:0] gathered[$];
    bit                   spilled;
    logic [WORD_BITS-1:0] heap[CAPACITY];
    sorted_word_t         awaited[$];

    function void sift_down(int unsigned n, int unsigned root);
      int unsigned i, big, l, r;
      logic [WORD_BITS-1:0] t;
      bit settled;
      i = root;
      settled = 0;
      while (!settled) begin
        big = i;
        l = 2 * i + 1;
        r = 2 * i + 2;
        if (l < n && $signed(heap[l]) > $signed(heap[big])) big = l;
        if (r < n && $signed(heap[r]) > $signed(heap[big])) big = r;
        if (big == i) begin
          settled = 1;
        end else begin
          t = heap[i];
          heap[i] = heap[big];
          heap[big] = t;
          i = big;
        end
      end
    endfunction

    // Note one accepted input word; the word marked last turns the set into expectations.
    function void note_word(logic [WORD_BITS-1:0] v, logic l);
      int unsigned n, k;
      logic [WORD_BITS-1:0] t;
      sorted_word_t w;
      if (gathered.size() < CAPACITY) gathered = {gathered, v};
      else spilled = 1;
      if (l) begin
        n = gathered.size();
        for (k = 0; k < n; k++) heap[k] = gathered[k];
        for (k = n / 2; k > 0; k--) sift_down(n, k - 1);
        for (k = n - 1; k > 0 && n > 1; k--) begin
          t = heap[0];
          heap[0] = heap[k];
          heap[k] = t;
          sift_down(k, 0);
        end
        for (k = 0; k < n; k++) begin
          w.value = heap[k];
          w.last  = (k + 1 == n);
          w.ovf   = spilled;
          awaited = {awaited, w};
        end
        gathered.delete();
        spilled = 0;
      end
    endfunction

    // Compare one output word with the oldest expectation; empty string when it matches.
    function string check_word(sorted_word_t got);
      sorted_word_t exp;
      string msg;
      if (awaited.size() == 0)
        return $sformatf("unexpected word %h last %b ovf %b", got.value, got.last, got.ovf);
      exp = awaited.pop_front();
      msg = "";
      if (got.value !== exp.value)
        msg = {msg, $sformatf(" value %h/%h", got.value, exp.value)};
      if (got.last !== exp.last)
        msg = {msg, $sformatf(" last_out %b/%b", got.last, exp.last)};
      if (got.ovf !== exp.ovf)
        msg = {msg, $sformatf(" overflow %b/%b", got.ovf, exp.ovf)};
      return msg;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

endpackage

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sort_check_pkg::*;

  localparam int  TARGET_ITEMS = 370;
  localparam int  HOLD_CYCLES  = 2500;   // long sink hold-off, beyond a full 64-word sort
  localparam int  TAIL_CYCLES  = 100;
  localparam real RUN_LIMIT_NS = 8.0e6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hse_in_if  #(.VALUE_WIDTH(WORD_BITS)) items_if ();
  hse_out_if #(.VALUE_WIDTH(WORD_BITS)) results_if ();

  heap_sort_engine #(
    .VALUE_WIDTH(WORD_BITS),
    .MAX_ITEMS  (CAPACITY)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .results(results_if)
  );

  sort_scoreboard sorted_sb = new();

  int errors     = 0;
  int items_sent = 0;
  int burst_left = 0;
  logic hold_req = 1'b0;

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("[%0t] error:%s", $realtime, msg);
    errors++;
  endtask

  // Pick a word from one of several value styles: full range, a narrow band that makes
  // duplicates likely, the extremes, zero or minus one, or words at or just inside the extremes.
  function automatic logic [WORD_BITS-1:0] pick_value(int style);
    case (style)
      0:       return $urandom;
      1:       return $urandom_range(0, 7) - 4;
      2:       case ($urandom_range(0, 3))
                 0:       return 32'h8000_0000;
                 1:       return 32'h7fff_ffff;
                 2:       return 32'h0000_0000;
                 default: return 32'hffff_ffff;
               endcase
      default: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                           : 32'h7fff_ffff - $urandom_range(0, 3);
    endcase
  endfunction

  // Offer one word and hold it until accepted. Valid stays high inside a burst; at the end
  // of a burst drop it for a random gap, sometimes none at all.
  task automatic send_word(input logic [WORD_BITS-1:0] v, input logic l);
    int gap;
    items_if.valid <= 1'b1;
    items_if.value <= v;
    items_if.last  <= l;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    sorted_sb.note_word(v, l);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        items_if.valid <= 1'b0;
        items_if.value <= $urandom;
        items_if.last  <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_list(input logic [WORD_BITS-1:0] vals[$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_set(input int count);
    int style;
    style = $urandom_range(0, 4);
    for (int i = 0; i < count; i++)
      send_word(pick_value(style == 4 ? $urandom_range(0, 3) : style), i == count - 1);
  endtask

  // Stop offering and wait for every expected word to come back.
  task automatic pause_until_drained();
    items_if.valid <= 1'b0;
    while (sorted_sb.outstanding() != 0) @(posedge clk);
  endtask

  // Sink side: check each accepted word, then choose ready for the next cycle. The stall
  // pattern switches at random among four modes; a hold request forces a long stretch of no ready.
  initial begin
    int hold_left;
    int mode;
    int cyc;
    sorted_word_t got;
    string msg;
    hold_left = 0;
    mode = 0;
    cyc = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_if.valid && results_if.ready) begin
        got.value = results_if.sorted_value;
        got.last  = results_if.last_out;
        got.ovf   = results_if.overflow;
        msg = sorted_sb.check_word(got);
        if (msg != "") report(msg);
      end
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
        results_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       results_if.ready <= 1'b1;
          1:       results_if.ready <= 1'($urandom_range(0, 1));
          2:       results_if.ready <= ($urandom_range(0, 3) == 0);
          default: results_if.ready <= ((cyc / 8) % 2 == 0);
        endcase
      end
    end
  end

  // Stimulus: reset, directed sets, forced capacity cases, then random sets.
  initial begin
    logic [WORD_BITS-1:0] vals[$];
    int set_no;
    items_if.valid <= 1'b0;
    items_if.value <= '0;
    items_if.last  <= 1'b0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-word set holding the most negative value
    vals = '{32'h8000_0000};
    send_list(vals);
    // extremes, zero, minus one and a repeated maximum
    vals = '{32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h1};
    send_list(vals);
    // two words in falling order
    vals = '{32'd5, -32'sd5};
    send_list(vals);
    // already ascending, then strictly descending
    vals = '{32'd1, 32'd2, 32'd3, 32'd4};
    send_list(vals);
    vals = '{32'd5, 32'd4, 32'd3, 32'd2, 32'd1};
    send_list(vals);
    // all equal
    vals = '{32'd42, 32'd42, 32'd42};
    send_list(vals);
    pause_until_drained();

    // exactly full, then one over with the last word itself dropped, then well over
    send_set(CAPACITY);
    send_set(CAPACITY + 1);
    send_set(CAPACITY + 6);
    pause_until_drained();

    set_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      set_no++;
      if (set_no == 4) begin
        // hold the sink off while two sets go in, so the engine backs up onto its input
        hold_req <= 1'b1;
        send_set($urandom_range(16, 24));
        send_set($urandom_range(4, 10));
      end else if ($urandom_range(0, 9) == 0) begin
        send_set($urandom_range(CAPACITY - 8, CAPACITY + 8));
      end else begin
        send_set($urandom_range(1, 12));
      end
      if (set_no % 7 == 0) pause_until_drained();
    end

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d words still expected", sorted_sb.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hse_pkg.sv
rtl/hse_if.sv
rtl/hse_cmp.sv
rtl/hse_mem.sv
rtl/hse_seq.sv
rtl/heap_sort_engine.sv
rtl/hse_chk.sv
sim/tb.sv
